### rtl/utu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the UTF-8 to UTF-16 transcoder.
// No dependencies; used by the decoder, the top level and the testbench.
package utu_pkg;

    localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam int          MAX_UNITS    = 3;
    localparam int          HELD_DEPTH   = 3;
    localparam int          RUN_DEPTH    = 4;

    // Sequence bookkeeping kept between bytes
    typedef struct packed {
        logic [1:0] held_count;
        logic [2:0] needed_length;
    } utu_ctl_t;

    // Held-byte write request from the decoder
    typedef struct packed {
        logic       we;
        logic [1:0] wa;
    } utu_hold_t;

    // Units produced by one input byte
    typedef struct packed {
        logic [1:0]                 n;
        logic [MAX_UNITS-1:0][15:0] units;
    } utu_dec_t;

    // Sequence length from a lead byte; 0 marks an invalid lead
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] l;
        if (!b[7])
            l = 3'd1;
        else if (!b[6])
            l = 3'd0;
        else if (!b[5])
            l = 3'd2;
        else if (!b[4])
            l = 3'd3;
        else if (!b[3])
            l = 3'd4;
        else
            l = 3'd0;
        return l;
    endfunction

    // Payload bits of a lead byte for a given sequence length
    function automatic logic [20:0] lead_bits(input logic [7:0] b, input logic [2:0] l);
        logic [20:0] v;
        case (l)
            3'd1:    v = {14'd0, b[6:0]};
            3'd2:    v = {16'd0, b[4:0]};
            3'd3:    v = {17'd0, b[3:0]};
            3'd4:    v = {18'd0, b[2:0]};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/utu_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the transcoder: UTF-8 byte input, UTF-16 unit output.
// Standalone; no package dependency.
interface utu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       string_end;

    modport source (output valid, output byte_value, output string_end, input ready);
    modport sink   (input valid, input byte_value, input string_end, output ready);
endinterface

interface utu_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] utf16_unit;
    logic        run_last;
    logic        string_done;

    modport source (output valid, output utf16_unit, output run_last, output string_done,
                    input ready);
    modport sink   (input valid, input utf16_unit, input run_last, input string_done,
                    output ready);
endinterface

### rtl/utu_decode.sv
`timescale 1ns / 1ps
// Combinational UTF-8 sequence decoder: one byte plus held state in, up to three units out.
// Depends on utu_pkg.
module utu_decode (
    input  logic [7:0]                        byte_value,
    input  logic                              string_end,
    input  utu_pkg::utu_ctl_t                 ctl,
    input  logic [utu_pkg::HELD_DEPTH-1:0][7:0] held,
    output utu_pkg::utu_ctl_t                 ctl_next,
    output utu_pkg::utu_hold_t                hold,
    output utu_pkg::utu_dec_t                 dec
);

    always_comb
    begin : decode_c
        logic [7:0]  run_b [utu_pkg::RUN_DEPTH];
        logic [2:0]  run_len;
        logic        do_run;
        logic [2:0]  l;
        logic [2:0]  li;
        logic [1:0]  skip;
        logic [1:0]  n_v;
        logic [1:0]  cnt;
        logic [20:0] cp;
        logic [20:0] off;

        ctl_next = ctl;
        hold     = '0;
        dec      = '0;
        do_run   = 1'b0;
        run_len  = 3'd1;
        skip     = '0;
        n_v      = '0;
        cp       = '0;
        off      = '0;
        li       = '0;
        cnt      = ctl.held_count;
        l        = utu_pkg::seq_len(byte_value);

        for (int k = 0; k < utu_pkg::HELD_DEPTH; k++)
        begin
            run_b[k] = (2'(k) < cnt) ? held[k] : byte_value;
        end
        run_b[utu_pkg::RUN_DEPTH-1] = byte_value;

        if (ctl.needed_length == 3'd0)
        begin
            if (l <= 3'd1 || string_end)
            begin
                do_run  = 1'b1;
                run_len = 3'd1;
            end
            else
            begin
                hold.we                = 1'b1;
                hold.wa                = 2'd0;
                ctl_next.held_count    = 2'd1;
                ctl_next.needed_length = l;
            end
        end
        else if (({1'b0, cnt} + 3'd1) == ctl.needed_length || string_end || cnt == 2'd3)
        begin
            do_run                 = 1'b1;
            run_len                = {1'b0, cnt} + 3'd1;
            ctl_next.held_count    = '0;
            ctl_next.needed_length = '0;
        end
        else
        begin
            hold.we             = 1'b1;
            hold.wa             = cnt;
            ctl_next.held_count = cnt + 2'd1;
        end

        // Walk the run; a lead short of bytes yields a replacement and decoding resumes
        for (int i = 0; i < utu_pkg::RUN_DEPTH; i++)
        begin
            if (do_run && 3'(i) < run_len)
            begin
                if (skip != 2'd0)
                begin
                    skip = skip - 2'd1;
                end
                else
                begin
                    li = utu_pkg::seq_len(run_b[i]);
                    if (li == 3'd0 || (run_len - 3'(i)) < li)
                    begin
                        if (n_v != 2'd3)
                        begin
                            dec.units[n_v] = utu_pkg::REPL_CHAR;
                            n_v = n_v + 2'd1;
                        end
                    end
                    else
                    begin
                        cp = utu_pkg::lead_bits(run_b[i], li);
                        for (int k = 1; k < utu_pkg::RUN_DEPTH; k++)
                        begin
                            if (i + k < utu_pkg::RUN_DEPTH && 3'(k) < li)
                            begin
                                cp = {cp[14:0], run_b[2'(i + k)][5:0]};
                            end
                        end
                        if (cp < utu_pkg::SUPP_BASE)
                        begin
                            if (n_v != 2'd3)
                            begin
                                dec.units[n_v] = cp[15:0];
                                n_v = n_v + 2'd1;
                            end
                        end
                        else
                        begin
                            off = cp - utu_pkg::SUPP_BASE;
                            if (n_v != 2'd3)
                            begin
                                dec.units[n_v] = utu_pkg::HI_SURR_BASE | {6'd0, off[19:10]};
                                n_v = n_v + 2'd1;
                            end
                            if (n_v != 2'd3)
                            begin
                                dec.units[n_v] = utu_pkg::LO_SURR_BASE | {6'd0, off[9:0]};
                                n_v = n_v + 2'd1;
                            end
                        end
                        skip = 2'(li - 3'd1);
                    end
                end
            end
        end
        dec.n = n_v;
    end

endmodule

### rtl/utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 to UTF-16 transcoder: input register, decoder, result register.
// Depends on utu_pkg, utu_stream_if and utu_decode.

// Bytes enter one per transfer on utf8 and units leave one per transfer on utf16. A byte waits
// in the input register until it can advance, is decoded against the open sequence, and its
// units (none, one, two or three) are loaded into a three-entry result register that drains
// one unit per cycle while the receiver is ready. With at most one unit per byte the block
// runs at one byte per clock; a byte with more units holds the input while they drain through
// the single output port. run_last marks a byte's last unit, string_done a string's.
module utf8_to_utf16_transcoder (
    input  logic              clk,
    input  logic              rst_n,
    utu_byte_if.sink          utf8,
    utu_unit_if.source        utf16
);

    logic                                  inv_reg;
    logic [7:0]                            inb_reg;
    logic                                  ine_reg;
    utu_pkg::utu_ctl_t                     ctl_reg;
    utu_pkg::utu_ctl_t                     ctl_next;
    logic [utu_pkg::HELD_DEPTH-1:0][7:0]   held_reg;
    utu_pkg::utu_hold_t                    hold;
    utu_pkg::utu_dec_t                     dec;
    logic [utu_pkg::MAX_UNITS-1:0][15:0]   res_unit_reg;
    logic [1:0]                            res_left_reg;
    logic [1:0]                            res_idx_reg;
    logic                                  res_end_reg;
    logic                                  adv;
    logic                                  out_xfer;

    assign out_xfer   = utf16.valid && utf16.ready;
    assign adv        = inv_reg && (res_left_reg == 2'd0 || (res_left_reg == 2'd1 && utf16.ready));
    assign utf8.ready = !inv_reg || adv;

    utu_decode u_decode (
        .byte_value (inb_reg),
        .string_end (ine_reg),
        .ctl        (ctl_reg),
        .held       (held_reg),
        .ctl_next   (ctl_next),
        .hold       (hold),
        .dec        (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg      <= 1'b0;
            ctl_reg      <= '0;
            res_left_reg <= '0;
            res_idx_reg  <= '0;
        end
        else
        begin
            if (utf8.valid && utf8.ready)
                inv_reg <= 1'b1;
            else if (adv)
                inv_reg <= 1'b0;

            if (adv)
                ctl_reg <= ctl_next;

            if (adv)
            begin
                res_left_reg <= dec.n;
                res_idx_reg  <= '0;
            end
            else if (out_xfer)
            begin
                res_left_reg <= res_left_reg - 2'd1;
                res_idx_reg  <= res_idx_reg + 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (utf8.valid && utf8.ready)
        begin
            inb_reg <= utf8.byte_value;
            ine_reg <= utf8.string_end;
        end
        if (adv && hold.we)
            held_reg[hold.wa] <= inb_reg;
        if (adv)
        begin
            res_unit_reg <= dec.units;
            res_end_reg  <= ine_reg;
        end
    end

    assign utf16.valid       = res_left_reg != 2'd0;
    assign utf16.utf16_unit  = res_unit_reg[res_idx_reg];
    assign utf16.run_last    = res_left_reg == 2'd1;
    assign utf16.string_done = (res_left_reg == 2'd1) && res_end_reg;

    // Result slots never run past the three-entry register
    a_res_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        utf16.valid |-> ({1'b0, res_idx_reg} + {1'b0, res_left_reg}) <= 3'd3)
        else $error("result index runs past the result register");

    // An open sequence always holds at least its lead and is still short of bytes
    a_open_seq: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.needed_length != 3'd0 |->
            (ctl_reg.held_count != 2'd0 && {1'b0, ctl_reg.held_count} < ctl_reg.needed_length))
        else $error("open sequence bookkeeping inconsistent");

    // The final byte of a string always produces a unit
    a_end_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ine_reg) |-> dec.n != 2'd0)
        else $error("string end produced no unit");

    // No sequence stays open past the end of a string
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ine_reg) |=> ctl_reg.needed_length == 3'd0)
        else $error("sequence left open after string end");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for utf8_to_utf16_transcoder: directed and random UTF-8 strings in,
// UTF-16 units checked against an in-bench decoder. Depends on utu_pkg and utu_stream_if.
module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_BYTES = 105;

    typedef struct packed {
        logic [7:0] value;
        logic       fin;
    } utf8_byte_t;

    typedef struct packed {
        logic [15:0] unit;
        logic        run_last;
        logic        string_done;
    } utf16_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // bench-driven signals, known from time zero
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       in_end    = 1'b0;
    logic       out_ready = 1'b0;

    utu_byte_if utf8_bus ();
    utu_unit_if utf16_bus ();

    assign utf8_bus.valid      = in_valid;
    assign utf8_bus.byte_value = in_byte;
    assign utf8_bus.string_end = in_end;
    assign utf16_bus.ready     = out_ready;

    utf8_to_utf16_transcoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .utf8  (utf8_bus),
        .utf16 (utf16_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    utf8_byte_t  utf8_bytes_queued[$];
    utf16_word_t units_due[$];
    logic [15:0] decoded_units[$];

    // decoder state mirrored from the block
    logic [7:0] seq_bytes[3];
    logic [1:0] seq_count = 2'd0;
    logic [2:0] seq_need  = 3'd0;

    int errors       = 0;
    int bytes_sent   = 0;
    int units_seen   = 0;
    int strings_sent = 0;
    int cycle_count  = 0;

    logic calm      = 1'b0;
    int   calm_left = 0;
    int   gap_left  = 0;
    int   stall_left = 0;

    utf8_byte_t  next_byte;
    utf16_word_t next_unit;

    function automatic logic [2:0] utf8_len(input logic [7:0] b);
        casez (b[7:3])
            5'b0????: return 3'd1;
            5'b110??: return 3'd2;
            5'b1110?: return 3'd3;
            5'b11110: return 3'd4;
            default:  return 3'd0;   // continuation byte or 11111xxx
        endcase
    endfunction

    function automatic logic [20:0] lead_payload(input logic [7:0] b, input int l);
        case (l)
            1:       return {14'd0, b[6:0]};
            2:       return {16'd0, b[4:0]};
            3:       return {17'd0, b[3:0]};
            default: return {18'd0, b[2:0]};
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    task automatic add_unit(input logic [15:0] u);
        if (decoded_units.size() < utu_pkg::MAX_UNITS)
            decoded_units.push_back(u);
    endtask

    task automatic emit_codepoint(input logic [20:0] cp);
        logic [20:0] ofs;
        if (cp < utu_pkg::SUPP_BASE)
            add_unit(cp[15:0]);
        else
        begin
            // offset bits above 19 are dropped
            ofs = cp - utu_pkg::SUPP_BASE;
            add_unit(utu_pkg::HI_SURR_BASE | {6'd0, ofs[19:10]});
            add_unit(utu_pkg::LO_SURR_BASE | {6'd0, ofs[9:0]});
        end
    endtask

    // a lead without enough bytes behind it yields U+FFFD and decoding resumes at the next byte
    task automatic decode_bytes(input logic [7:0] run[4], input int len);
        int pos;
        int l;
        logic [20:0] cp;
        pos = 0;
        while (pos < len)
        begin
            l = utf8_len(run[pos]);
            if (l == 0 || len - pos < l)
            begin
                add_unit(utu_pkg::REPL_CHAR);
                pos++;
            end
            else
            begin
                cp = lead_payload(run[pos], l);
                for (int k = 1; k < l; k++)
                    cp = {cp[14:0], run[pos + k][5:0]};
                emit_codepoint(cp);
                pos += l;
            end
        end
    endtask

    task automatic transcode_byte(input logic [7:0] b, input logic fin);
        logic [7:0] run[4];
        int cnt;
        int l;
        decoded_units.delete();
        if (seq_need == 3'd0)
        begin
            l = utf8_len(b);
            if (l <= 1 || fin)
            begin
                run[0] = b;
                decode_bytes(run, 1);
            end
            else
            begin
                seq_bytes[0] = b;
                seq_count    = 2'd1;
                seq_need     = l[2:0];
            end
        end
        else
        begin
            cnt = seq_count;
            if (cnt + 1 == seq_need || fin || cnt >= 3)
            begin
                for (int k = 0; k < cnt; k++)
                    run[k] = seq_bytes[k];
                run[cnt] = b;
                decode_bytes(run, cnt + 1);
                seq_count = 2'd0;
                seq_need  = 3'd0;
            end
            else
            begin
                seq_bytes[cnt] = b;
                seq_count      = 2'(cnt + 1);
            end
        end
        foreach (decoded_units[i])
            units_due.push_back({decoded_units[i], i == decoded_units.size() - 1,
                                 (i == decoded_units.size() - 1) && fin});
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        utf8_bytes_queued.push_back({b, fin});
        if (fin)
            strings_sent++;
    endtask

    // continuation byte, now and then replaced by an arbitrary byte
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    task automatic queue_random_string(inout int count);
        logic [7:0] chr[4];
        int nchars;
        int clen;
        int kind;
        nchars = $urandom_range(1, 6);
        for (int c = 0; c < nchars; c++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 25)
            begin
                chr[0] = {1'b0, 7'($urandom_range(0, 127))};
                clen   = 1;
            end
            else if (kind < 45)
            begin
                chr[0] = {3'b110, 5'($urandom_range(0, 31))};
                clen   = 2;
            end
            else if (kind < 65)
            begin
                chr[0] = {4'b1110, 4'($urandom_range(0, 15))};
                clen   = 3;
            end
            else if (kind < 85)
            begin
                chr[0] = {5'b11110, 3'($urandom_range(0, 7))};
                clen   = 4;
            end
            else
            begin
                chr[0] = 8'($urandom_range(0, 255));
                clen   = 1;
            end
            for (int k = 1; k < clen; k++)
                chr[k] = cont_byte();
            // sometimes cut the closing sequence short at the string end
            if (c == nchars - 1 && clen > 1 && $urandom_range(0, 3) == 0)
                clen = $urandom_range(1, clen - 1);
            for (int k = 0; k < clen; k++)
                queue_byte(chr[k], (c == nchars - 1) && (k == clen - 1));
            count += clen;
        end
    endtask

    always @(posedge clk)
    begin
        if (calm_left == 0)
        begin
            calm      <= ($urandom_range(0, 2) == 0);
            calm_left <= $urandom_range(30, 150);
        end
        else
            calm_left <= calm_left - 1;
    end

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            in_end   <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && utf8_bus.ready)
            begin
                transcode_byte(in_byte, in_end);
                bytes_sent++;
            end
            if (!in_valid || utf8_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (utf8_bytes_queued.size() > 0)
                begin
                    next_byte = utf8_bytes_queued.pop_front();
                    in_valid  <= 1'b1;
                    in_byte   <= next_byte.value;
                    in_end    <= next_byte.fin;
                    gap_left  <= calm ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // unit monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (utf16_bus.valid && out_ready)
            begin
                units_seen++;
                if (units_due.size() == 0)
                begin
                    $error("unit %h with nothing expected", utf16_bus.utf16_unit);
                    errors++;
                end
                else
                begin
                    next_unit = units_due.pop_front();
                    if (utf16_bus.utf16_unit !== next_unit.unit)
                    begin
                        $error("utf16_unit: expected %h, got %h",
                               next_unit.unit, utf16_bus.utf16_unit);
                        errors++;
                    end
                    if (utf16_bus.run_last !== next_unit.run_last)
                    begin
                        $error("run_last: expected %b, got %b",
                               next_unit.run_last, utf16_bus.run_last);
                        errors++;
                    end
                    if (utf16_bus.string_done !== next_unit.string_done)
                    begin
                        $error("string_done: expected %b, got %b",
                               next_unit.string_done, utf16_bus.string_done);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d units still expected",
                 cycle_count, units_due.size());
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int random_count;
        random_count = 0;

        // ASCII extremes, ending a string on a plain byte
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b1);
        // stray continuation and 11111xxx leads
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hF8, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // two- and three-byte forms
        queue_byte(8'hC2, 1'b0);
        queue_byte(8'hA9, 1'b0);
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b0);
        queue_byte(8'hAC, 1'b1);
        // surrogate pair, then a four-byte form whose offset overflows 20 bits
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h9F, 1'b0);
        queue_byte(8'h98, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hF7, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b1);
        // lone lead as the final byte
        queue_byte(8'hE2, 1'b1);
        // cut short: the lead and both following bytes each give U+FFFD
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h9F, 1'b0);
        queue_byte(8'h98, 1'b1);
        // cut short, the bytes after the lead re-decode into a valid two-byte form
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'hA9, 1'b1);

        while (random_count < RANDOM_BYTES)
            queue_random_string(random_count);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (utf8_bytes_queued.size() > 0 || in_valid || units_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes in %0d strings sent, %0d UTF-16 units checked",
                 bytes_sent, strings_sent, units_seen);
        $display("covered invalid leads, surrogate pairs and sequences cut by string end");
        if (errors == 0 && units_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
